/* hdl/tws_pkg.sv */
// Shared types, constants and coefficient table of the three-way softmax choice block.
package tws_pkg;

  localparam int EXP_TABLE_BITS_DEF = 8;
  localparam logic [31:0] BETA_RESET = 32'd6553600;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [49:0] FLUSH_LIMIT = 50'd1048576;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [15:0] PROB_MAX = 16'hFFFF;
  localparam int HORNER_STEPS = 7;
  localparam int EXP_LAT = HORNER_STEPS + 4;
  localparam int DIV_BITS = 17;

  // Taylor coefficients of 2^-t in Q30, lowest order first.
  localparam logic [30:0] POW2_COEF [8] = '{
    31'd1073741824, 31'd744261118, 31'd257941248, 31'd59597083,
    31'd10327388, 31'd1431680, 31'd165394, 31'd16378
  };

  localparam logic [1:0] CHOICE_GREEN = 2'd0;
  localparam logic [1:0] CHOICE_BLACK = 2'd1;
  localparam logic [1:0] CHOICE_SAMPLE = 2'd2;

  typedef enum logic [1:0] {
    KIND_CALC = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_ZERO = 2'd2
  } kind_t;

  typedef struct packed {
    logic [32:0] diff;
    kind_t       kind;
  } lane_t;

endpackage

/* hdl/tws_diff.sv */
// Winner selection and per-option value differences, one register stage.
module tws_diff (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  val_g,
  input  logic signed [31:0]  val_b,
  input  logic signed [31:0]  val_s,
  input  logic                allowed,
  output logic                valid_r,
  output logic [1:0]          choice_r,
  output tws_pkg::lane_t      lane_g_r,
  output tws_pkg::lane_t      lane_b_r,
  output tws_pkg::lane_t      lane_s_r
);
  import tws_pkg::*;

  logic signed [31:0] best;
  logic [1:0]         choice_nxt;
  lane_t              lane_g_nxt, lane_b_nxt, lane_s_nxt;

  always_comb begin
    if (val_g >= val_b) begin
      choice_nxt = CHOICE_GREEN;
      best = val_g;
    end else begin
      choice_nxt = CHOICE_BLACK;
      best = val_b;
    end
    if (allowed && (val_s > best)) begin
      choice_nxt = CHOICE_SAMPLE;
      best = val_s;
    end
    lane_g_nxt.diff = {best[31], best} - {val_g[31], val_g};
    lane_b_nxt.diff = {best[31], best} - {val_b[31], val_b};
    lane_s_nxt.diff = {best[31], best} - {val_s[31], val_s};
    lane_g_nxt.kind = (choice_nxt == CHOICE_GREEN) ? KIND_ONE : KIND_CALC;
    lane_b_nxt.kind = (choice_nxt == CHOICE_BLACK) ? KIND_ONE : KIND_CALC;
    if (!allowed) begin
      lane_s_nxt.kind = KIND_ZERO;
    end else begin
      lane_s_nxt.kind = (choice_nxt == CHOICE_SAMPLE) ? KIND_ONE : KIND_CALC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      choice_r <= choice_nxt;
      lane_g_r <= lane_g_nxt;
      lane_b_r <= lane_b_nxt;
      lane_s_r <= lane_s_nxt;
    end
  end

endmodule

/* hdl/tws_exp.sv */
// Pipelined exp(-diff * beta) in Q30: scaling, base-2 split and Horner evaluation.
module tws_exp #(
  parameter int TABLE_BITS = tws_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [31:0]    beta,
  input  tws_pkg::lane_t lane,
  output logic           out_valid,
  output logic [30:0]    term_r
);
  import tws_pkg::*;

  localparam int DROP = 16 - TABLE_BITS;
  localparam logic [15:0] FRAC_MASK = 16'(16'hFFFF << DROP);

  // Stage 1: split product of the 33-bit difference and beta.
  logic        v1_r;
  logic [48:0] ph1_r;
  logic [47:0] pl1_r;
  kind_t       k1_r;
  // Stage 2: Q16.16 magnitude and flush test.
  logic        v2_r;
  logic [20:0] m2_r;
  kind_t       k2_r;
  logic [49:0] mag;
  // Stage 3: base-2 exponent split.
  logic        v3_r;
  logic [15:0] t3_r;
  logic [5:0]  ip3_r;
  kind_t       k3_r;
  logic [37:0] yprod;
  // Horner stages.
  logic        hv_r  [HORNER_STEPS];
  logic [30:0] hr_r  [HORNER_STEPS];
  logic [15:0] ht_r  [HORNER_STEPS];
  logic [5:0]  hip_r [HORNER_STEPS];
  kind_t       hk_r  [HORNER_STEPS];
  logic        vo_r;

  assign mag = 50'(ph1_r) + 50'(pl1_r[47:16]);
  assign yprod = 38'(m2_r) * 38'(LOG2E_Q16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph1_r <= 49'(lane.diff[32:16]) * 49'(beta);
      pl1_r <= 48'(lane.diff[15:0]) * 48'(beta);
      k1_r  <= lane.kind;
      m2_r  <= mag[20:0];
      k2_r  <= ((k1_r == KIND_CALC) && (mag > FLUSH_LIMIT)) ? KIND_ZERO : k1_r;
      t3_r  <= yprod[31:16] & FRAC_MASK;
      ip3_r <= yprod[37:32];
      k3_r  <= k2_r;
    end
  end

  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
    logic [30:0] r_in;
    logic [15:0] t_in;
    logic [5:0]  ip_in;
    kind_t       k_in;
    logic        v_in;
    logic [46:0] hp;
    if (j == 0) begin : g_first
      assign r_in  = POW2_COEF[HORNER_STEPS];
      assign t_in  = t3_r;
      assign ip_in = ip3_r;
      assign k_in  = k3_r;
      assign v_in  = v3_r;
    end else begin : g_next
      assign r_in  = hr_r[j-1];
      assign t_in  = ht_r[j-1];
      assign ip_in = hip_r[j-1];
      assign k_in  = hk_r[j-1];
      assign v_in  = hv_r[j-1];
    end
    assign hp = 47'(r_in) * 47'(t_in);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hv_r[j] <= 1'b0;
      end else if (en) begin
        hv_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hr_r[j]  <= POW2_COEF[HORNER_STEPS-1-j] - hp[46:16];
        ht_r[j]  <= t_in;
        hip_r[j] <= ip_in;
        hk_r[j]  <= k_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= hv_r[HORNER_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (hk_r[HORNER_STEPS-1])
        KIND_ONE:  term_r <= ONE_Q30;
        KIND_ZERO: term_r <= '0;
        default:   term_r <= hr_r[HORNER_STEPS-1] >> hip_r[HORNER_STEPS-1];
      endcase
    end
  end

  assign out_valid = vo_r;

endmodule

/* hdl/tws_div.sv */
// Pipelined restoring divider giving a rounded, saturated Q0.16 probability.
module tws_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [30:0] term,
  input  logic [31:0] den,
  output logic        out_valid,
  output logic [15:0] prob
);
  import tws_pkg::*;

  logic [47:0]         num;
  logic                dv_r [DIV_BITS];
  logic [47:0]         dr_r [DIV_BITS];
  logic [31:0]         dd_r [DIV_BITS];
  logic [DIV_BITS-1:0] dq_r [DIV_BITS];

  assign num = {1'b0, term, 16'b0} + 48'(den[31:1]);

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_bit
    localparam int B = DIV_BITS - 1 - i;
    logic                v_in;
    logic [47:0]         rem_in;
    logic [31:0]         den_in;
    logic [DIV_BITS-1:0] q_in;
    logic [47:0]         sh;
    logic                ge;
    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign v_in   = dv_r[i-1];
      assign rem_in = dr_r[i-1];
      assign den_in = dd_r[i-1];
      assign q_in   = dq_r[i-1];
    end
    assign sh = 48'(den_in) << B;
    assign ge = rem_in >= sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i] <= 1'b0;
      end else if (en) begin
        dv_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dr_r[i] <= ge ? (rem_in - sh) : rem_in;
        dd_r[i] <= den_in;
        dq_r[i] <= q_in | (DIV_BITS'(ge) << B);
      end
    end
  end

  assign out_valid = dv_r[DIV_BITS-1];
  assign prob = dq_r[DIV_BITS-1][DIV_BITS-1] ? PROB_MAX : dq_r[DIV_BITS-1][15:0];

endmodule

/* hdl/three_way_softmax_choice_top.sv */
// Top level of the three-way softmax choice block.
//
//  Channel  Ports                    Contents
//  input    in_tvalid/tready/tdata   value_green, value_black, value_sample
//           in_tuser                 sample_allowed
//  result   out_tvalid/tready/tdata  choice, prob_green, prob_black, prob_sample
//  config   cfg_wr_en/cfg_wr_data    inverse_temperature (Q16.16)
//
// The block is a single pipeline (1 difference stage, 11 exponential stages,
// 1 denominator stage, 17 divider stages) that accepts one item every cycle
// unless the output stalls. The divider, one quotient bit per stage, sets the
// depth. Reset clears all valid bits and loads the inverse temperature with
// 100.0. When the result at the output is not taken, the whole pipeline holds
// in place, so nothing is lost or repeated.
module three_way_softmax_choice_top #(
  parameter int EXP_TABLE_BITS = tws_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // value_green, value_black, value_sample
  input  logic        in_tuser,   // sample_allowed
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // choice, prob_green, prob_black, prob_sample
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import tws_pkg::*;

  localparam int CH_LAT = EXP_LAT + 1 + DIV_BITS;

  logic        en;
  logic [31:0] beta_r;

  logic        d_valid;
  logic [1:0]  d_choice;
  lane_t       lane_g, lane_b, lane_s;

  logic        e_valid;
  logic [30:0] term_g, term_b, term_s;

  // Denominator stage.
  logic        s_valid_r;
  logic [30:0] s_g_r, s_b_r, s_s_r;
  logic [31:0] den_r;

  logic        q_valid;
  logic [15:0] p_g, p_b, p_s;
  logic [1:0]  choice_dly_r [CH_LAT];

  // The pipeline moves whenever the output register is free or being emptied.
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= BETA_RESET;
    end else if (cfg_wr_en) begin
      beta_r <= cfg_wr_data;
    end
  end

  tws_diff u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .val_g    ($signed(in_tdata[31:0])),
    .val_b    ($signed(in_tdata[63:32])),
    .val_s    ($signed(in_tdata[95:64])),
    .allowed  (in_tuser),
    .valid_r  (d_valid),
    .choice_r (d_choice),
    .lane_g_r (lane_g),
    .lane_b_r (lane_b),
    .lane_s_r (lane_s)
  );

  // Three identical exponential lanes run in lockstep.
  tws_exp #(.TABLE_BITS(EXP_TABLE_BITS)) u_exp_g (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(d_valid), .beta(beta_r),
    .lane(lane_g), .out_valid(e_valid), .term_r(term_g)
  );
  tws_exp #(.TABLE_BITS(EXP_TABLE_BITS)) u_exp_b (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(d_valid), .beta(beta_r),
    .lane(lane_b), .out_valid(), .term_r(term_b)
  );
  tws_exp #(.TABLE_BITS(EXP_TABLE_BITS)) u_exp_s (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(d_valid), .beta(beta_r),
    .lane(lane_s), .out_valid(), .term_r(term_s)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (en) begin
      s_valid_r <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_g_r <= term_g;
      s_b_r <= term_b;
      s_s_r <= term_s;
      den_r <= 32'(term_g) + 32'(term_b) + 32'(term_s);
    end
  end

  tws_div u_div_g (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_valid_r), .term(s_g_r),
    .den(den_r), .out_valid(q_valid), .prob(p_g)
  );
  tws_div u_div_b (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_valid_r), .term(s_b_r),
    .den(den_r), .out_valid(), .prob(p_b)
  );
  tws_div u_div_s (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_valid_r), .term(s_s_r),
    .den(den_r), .out_valid(), .prob(p_s)
  );

  // The choice code rides alongside the arithmetic lanes.
  always_ff @(posedge clk) begin
    if (en) begin
      choice_dly_r[0] <= d_choice;
      for (int k = 1; k < CH_LAT; k++) begin
        choice_dly_r[k] <= choice_dly_r[k-1];
      end
    end
  end

  assign out_tvalid = q_valid;
  assign out_tdata  = {6'b0, p_s, p_b, p_g, choice_dly_r[CH_LAT-1]};

  // The three rounded probabilities sum to one within rounding and saturation.
  a_prob_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((18'(p_g) + 18'(p_b) + 18'(p_s)) >= 18'd65534) &&
                   ((18'(p_g) + 18'(p_b) + 18'(p_s)) <= 18'd65537))
    else $error("probabilities do not sum to one");

  // The chosen option carries the largest probability.
  a_choice_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ((out_tdata[1:0] == CHOICE_GREEN) && (p_g >= p_b) && (p_g >= p_s)) ||
      ((out_tdata[1:0] == CHOICE_BLACK) && (p_b >= p_g) && (p_b >= p_s)) ||
      ((out_tdata[1:0] == CHOICE_SAMPLE) && (p_s >= p_g) && (p_s >= p_b)))
    else $error("choice does not hold the largest probability");

  // A sample choice is only possible with a nonzero sample probability.
  a_sample_prob: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] == CHOICE_SAMPLE)) |-> (p_s != 16'd0))
    else $error("sample chosen with zero probability");

endmodule

/* test/tb.sv */
// Self-checking testbench of the three-way softmax choice block.
`timescale 1ns / 100ps

module tb;
  import tws_pkg::*;

  // One decision item as seen on the input channel.
  typedef struct packed {
    logic [31:0] q_green;
    logic [31:0] q_black;
    logic [31:0] q_sample;
    logic        allowed;
  } decision_t;

  // One result item: choice and the three probabilities.
  typedef struct packed {
    logic [1:0]  choice;
    logic [15:0] p_green;
    logic [15:0] p_black;
    logic [15:0] p_sample;
  } verdict_t;

  localparam int PIPE_LAT = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // value_green, value_black, value_sample
  logic        in_tuser = 1'b0; // sample_allowed
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;       // choice, prob_green, prob_black, prob_sample
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  // The predictor's own copy of the inverse temperature.
  logic [31:0] beta_model;
  verdict_t    verdict_queue[$];
  int          error_count = 0;

  // Idle control: percentages and the stall that fills the pipeline.
  int  send_idle_pct = 36;
  int  recv_idle_pct = 36;
  int  hold_cycles = 0;

  three_way_softmax_choice_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Exponential of a non-positive value whose magnitude is given in Q16.16,
  // returned in Q30 from a truncated base-2 Horner evaluation.
  function automatic logic [63:0] exp_neg_q30(logic [63:0] mag);
    logic [63:0] y, ip, t, r;
    if (mag > 64'(FLUSH_LIMIT)) return 64'd0;
    y  = (mag * 64'd94548) >> 16;
    ip = y >> 16;
    t  = ((y & 64'hFFFF) >> (16 - EXP_TABLE_BITS_DEF)) << (16 - EXP_TABLE_BITS_DEF);
    r  = 64'(POW2_COEF[7]);
    for (int k = 6; k >= 0; k--) r = 64'(POW2_COEF[k]) - ((r * t) >> 16);
    if (ip > 30) return 64'd0;
    return r >> ip;
  endfunction

  // Term of an option that lost: exp(-(best - value) * beta).
  function automatic logic [63:0] loser_weight(logic signed [63:0] best,
                                               logic signed [63:0] val);
    logic [63:0] diff;
    diff = 64'(best - val);
    return exp_neg_q30((diff * 64'(beta_model)) >> 16);
  endfunction

  function automatic logic [15:0] share_q16(logic [63:0] term, logic [63:0] den);
    logic [63:0] p;
    p = (term * 64'd65536 + den / 2) / den;
    return (p > 64'(PROB_MAX)) ? PROB_MAX : p[15:0];
  endfunction

  function automatic verdict_t softmax_choice(decision_t d);
    logic signed [63:0] qg, qb, qs, best;
    logic [63:0] eg, eb, es, den;
    verdict_t v;
    qg = 64'(signed'(d.q_green));
    qb = 64'(signed'(d.q_black));
    qs = 64'(signed'(d.q_sample));
    if (qg >= qb) begin
      v.choice = CHOICE_GREEN;
      best = qg;
    end else begin
      v.choice = CHOICE_BLACK;
      best = qb;
    end
    if (d.allowed && qs > best) begin
      v.choice = CHOICE_SAMPLE;
      best = qs;
    end
    eg = (v.choice == CHOICE_GREEN) ? 64'(ONE_Q30) : loser_weight(best, qg);
    eb = (v.choice == CHOICE_BLACK) ? 64'(ONE_Q30) : loser_weight(best, qb);
    if (!d.allowed) es = 64'd0;
    else es = (v.choice == CHOICE_SAMPLE) ? 64'(ONE_Q30) : loser_weight(best, qs);
    den = eg + eb + es;
    v.p_green  = share_q16(eg, den);
    v.p_black  = share_q16(eb, den);
    v.p_sample = share_q16(es, den);
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Sends one item; the expectation is queued when the handshake completes.
  // The valid line stays up between items sent back to back.
  task automatic send_decision(decision_t d);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d.q_sample, d.q_black, d.q_green};
    in_tuser  <= d.allowed;
    do @(posedge clk); while (!in_tready);
    verdict_queue.push_back(softmax_choice(d));
  endtask

  // Drops the valid line after the last item of a group.
  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes the inverse temperature once the pipeline has drained.
  task automatic set_beta(logic [31:0] beta);
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= beta;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    beta_model = beta;
  endtask

  // Receiver: idles at random, or holds off completely while hold_cycles runs.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.choice   = out_tdata[1:0];
      got.p_green  = out_tdata[17:2];
      got.p_black  = out_tdata[33:18];
      got.p_sample = out_tdata[49:34];
      if (verdict_queue.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], 32'd0);
      end else begin
        want = verdict_queue.pop_front();
        if (got.choice != want.choice)
          report_mismatch("choice", 32'(got.choice), 32'(want.choice));
        if (got.p_green != want.p_green)
          report_mismatch("prob_green", 32'(got.p_green), 32'(want.p_green));
        if (got.p_black != want.p_black)
          report_mismatch("prob_black", 32'(got.p_black), 32'(want.p_black));
        if (got.p_sample != want.p_sample)
          report_mismatch("prob_sample", 32'(got.p_sample), 32'(want.p_sample));
      end
    end
  end

  // Random Q16.16 value; often near a base so that differences stay in the
  // range where the exponential is not flushed.
  function automatic logic [31:0] near(logic [31:0] base);
    case ($urandom_range(3))
      0: return $urandom;
      1: return base;
      default: return base + 32'(signed'($urandom_range(8192)) - 4096);
    endcase
  endfunction

  function automatic decision_t random_decision();
    decision_t d;
    logic [31:0] base;
    base = ($urandom_range(3) == 0) ? $urandom : 32'(signed'($urandom_range(20'hFFFFF)) - 524288);
    d.q_green  = near(base);
    d.q_black  = near(base);
    d.q_sample = near(base);
    d.allowed  = 1'($urandom_range(1));
    return d;
  endfunction

  // Extremes of the fields, ties, each winner, sampling off and uniform cases.
  task automatic test_directed();
    decision_t list[$];
    list.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1});
    list.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1});
    list.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1});
    list.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0});
    list.push_back('{32'h0, 32'h0, 32'h0, 1'b1});
    list.push_back('{32'h0, 32'h0, 32'h0, 1'b0});
    list.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    list.push_back('{32'h0001_0000, 32'h0001_0000, 32'h0, 1'b1});
    list.push_back('{32'h0001_0000, 32'h0001_0100, 32'h0000_FF00, 1'b1});
    list.push_back('{32'h0, 32'h0, 32'h0000_0001, 1'b1});
    list.push_back('{32'h0, 32'h0000_0200, 32'h0000_0400, 1'b0});
    list.push_back('{32'h0000_0800, 32'h0, 32'hFFFF_F800, 1'b1});
    list.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5554, 1'b1});
    list.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5556, 1'b1});
    foreach (list[i]) send_decision(list[i]);
    stop_sending();
  endtask

  task automatic test_random(int count);
    repeat (count) send_decision(random_decision());
    stop_sending();
  endtask

  // The receiver stops for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_cycles = 200;
    send_idle_pct = 0;
    repeat (80) send_decision(random_decision());
    stop_sending();
    send_idle_pct = 36;
  endtask

  // A stretch with no idling on either side.
  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (150) send_decision(random_decision());
    stop_sending();
    send_idle_pct = 36;
    recv_idle_pct = 36;
  endtask

  initial begin
    beta_model = BETA_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250);
    test_backpressure();
    test_full_rate();
    // Settings across the range: zero temperature factor gives uniform terms,
    // the all-ones value flushes almost every loser.
    set_beta(32'd0);
    test_directed();
    test_random(100);
    set_beta(32'hFFFF_FFFF);
    test_random(100);
    set_beta(32'd1);
    test_random(100);
    set_beta(32'h0001_0000);
    test_directed();
    test_random(150);
    set_beta($urandom);
    test_random(100);
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
hdl/tws_pkg.sv
hdl/tws_diff.sv
hdl/tws_exp.sv
hdl/tws_div.sv
hdl/three_way_softmax_choice_top.sv
test/tb.sv
